/* rtl/spi_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package spi_pkg;

  localparam int COLOR_W = 24;
  localparam int RANK_W  = 10;
  localparam int COUNT_W = 11;
  localparam int IB_W    = 3;

  // fan-in of one node of the registered OR tree
  localparam int FANIN = 32;

  localparam int RANK_MAX          = 1023;
  localparam int COUNT_MAX         = 2047;
  localparam int BYTE_INDEX_LIMIT  = 256;
  localparam int SHORT_INDEX_LIMIT = 65536;

  localparam logic [IB_W-1:0] IB_ONE  = 3'd1;
  localparam logic [IB_W-1:0] IB_TWO  = 3'd2;
  localparam logic [IB_W-1:0] IB_FOUR = 3'd4;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUSY,
    ST_DONE
  } state_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic               take;     // item accepted: compare and latch contribution
    op_t                op;
    logic [COLOR_W-1:0] color;
    logic [RANK_W-1:0]  rank_in;
    logic               ins;      // shift in color at the boundary
    logic               clr;      // drop all entries
  } cmd_t;

  // what a cell hands to its upper neighbor
  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               valid;
    logic               lt_now;   // valid and smaller than the broadcast color
    logic               lt_r;     // the same, latched when the item was taken
  } link_t;

endpackage

`default_nettype wire

/* rtl/sorted_palette_indexer.sv */
`timescale 1ns / 1ps
`default_nettype none

// Sorted color palette: a row of MAX_COLORS cells holds the distinct colors in
// ascending order. An accepted item is compared against every cell at once;
// the per-cell results are merged by a registered OR tree of fan-in 32, and
// an insert then shifts the upper part of the row up by one cell. Each item
// goes through these steps in order: the accepting cycle latches the compares,
// the L = ceil(log32(MAX_COLORS)) tree levels run the tree, the result is
// captured in a pending register, and it is handed to the output register
// once that register is free. No new item is taken before that hand-off. The
// result sits in an output register, so the next item is taken while it
// waits. Ranks saturate at 1023 and the unique count at 2047.
module sorted_palette_indexer #(
  parameter int MAX_COLORS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_op,
  input  logic [spi_pkg::COLOR_W-1:0]   in_pixel_color,
  input  logic [spi_pkg::RANK_W-1:0]    in_rank_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [spi_pkg::RANK_W-1:0]    out_color_rank,
  output logic                          out_found,
  output logic [spi_pkg::COLOR_W-1:0]   out_palette_color,
  output logic [spi_pkg::COUNT_W-1:0]   out_unique_count,
  output logic [spi_pkg::IB_W-1:0]      out_index_bytes,
  output logic                          out_overflow
);
  import spi_pkg::*;

  function automatic int lvl_size(input int k);
    int s;
    s = MAX_COLORS;
    for (int i = 0; i < k; i++) begin
      s = (s + FANIN - 1) / FANIN;
    end
    return s;
  endfunction

  function automatic int num_levels();
    int s;
    int n;
    s = MAX_COLORS;
    n = 0;
    for (int i = 0; i < 8; i++) begin
      if (s > 1) begin
        s = (s + FANIN - 1) / FANIN;
        n = n + 1;
      end
    end
    return n;
  endfunction

  function automatic int lvl_off(input int k);
    int o;
    o = 0;
    for (int i = 0; i < k; i++) begin
      o = o + lvl_size(i);
    end
    return o;
  endfunction

  localparam int IW    = $clog2(MAX_COLORS);
  localparam int CW    = 2 + IW + COLOR_W;
  localparam int CNT_W = $clog2(MAX_COLORS + 1);
  localparam int WIDE  = (CNT_W > 17) ? CNT_W : 17;
  localparam int L     = num_levels();
  localparam int T     = lvl_off(L + 1);
  localparam int ROOT  = lvl_off(L);
  localparam int LCW   = $clog2(L + 1);

  // ---------------------------------------------------------------- control
  state_t             state_r, state_nxt;
  logic [LCW-1:0]     lvl_cnt_r, lvl_cnt_nxt;
  logic               take;
  logic               fin;
  logic               load_out;

  op_t                op_r;
  logic [COLOR_W-1:0] color_r;
  logic [RANK_W-1:0]  rank_in_r;

  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               ovf_r, ovf_nxt;

  cmd_t               cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      lvl_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      lvl_cnt_r <= lvl_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    lvl_cnt_nxt = lvl_cnt_r;
    in_ready    = 1'b0;
    fin         = 1'b0;
    load_out    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt   = ST_BUSY;
          lvl_cnt_nxt = '0;
        end
      end
      ST_BUSY: begin
        // the root holds the merged result once all L levels have advanced
        if (lvl_cnt_r == LCW'(L)) begin
          fin       = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          lvl_cnt_nxt = LCW'(lvl_cnt_r + 1'b1);
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign take = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (take) begin
      op_r      <= op_t'(in_op);
      color_r   <= in_pixel_color;
      rank_in_r <= in_rank_in;
    end
  end

  // ---------------------------------------------------------------- cells
  link_t              link [MAX_COLORS];
  wire  [T-1:0][CW-1:0] node;

  logic               sel_any;
  logic               eq_any;
  logic [IW-1:0]      sel_idx;
  logic [COLOR_W-1:0] sel_color;
  logic               full;
  logic               ins_en;

  assign full   = (count_r == CNT_W'(MAX_COLORS));
  assign ins_en = fin && (op_r == OP_INSERT) && !eq_any && !full;

  always_comb begin
    cmd.take    = take;
    cmd.op      = take ? op_t'(in_op) : op_r;
    cmd.color   = take ? in_pixel_color : color_r;
    cmd.rank_in = take ? in_rank_in : rank_in_r;
    cmd.ins     = ins_en;
    cmd.clr     = fin && (op_r == OP_CLEAR);
  end

  for (genvar i = 0; i < MAX_COLORS; i++) begin : g_cell
    link_t prev;
    if (i == 0) begin : g_head
      assign prev = '{color: '0, valid: 1'b1, lt_now: 1'b1, lt_r: 1'b1};
    end else begin : g_body
      assign prev = link[i-1];
    end
    spi_cell #(
      .IDX (i),
      .IW  (IW)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (cmd),
      .prev  (prev),
      .link  (link[i]),
      .con   (node[i])
    );
  end

  for (genvar k = 0; k < L; k++) begin : g_lvl
    spi_or_stage #(
      .NI (lvl_size(k)),
      .NO (lvl_size(k + 1)),
      .W  (CW)
    ) u_stage (
      .clk  (clk),
      .din  (node[lvl_off(k) +: lvl_size(k)]),
      .dout (node[lvl_off(k + 1) +: lvl_size(k + 1)])
    );
  end

  assign sel_any   = node[ROOT][CW-1];
  assign eq_any    = node[ROOT][CW-2];
  assign sel_idx   = node[ROOT][COLOR_W +: IW];
  assign sel_color = node[ROOT][COLOR_W-1:0];

  // ---------------------------------------------------------------- result
  logic [CNT_W-1:0]   rank_full;
  logic [WIDE-1:0]    rank_wide;
  logic [WIDE-1:0]    count_wide;
  logic [RANK_W-1:0]  res_rank;
  logic               res_found;
  logic [COLOR_W-1:0] res_color;

  logic [RANK_W-1:0]  pend_rank_r;
  logic               pend_found_r;
  logic [COLOR_W-1:0] pend_color_r;
  logic [COUNT_W-1:0] pend_count_r;
  logic [IB_W-1:0]    pend_ib_r;
  logic               pend_ovf_r;
  logic [COUNT_W-1:0] res_count;
  logic [IB_W-1:0]    res_ib;

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (fin) begin
      unique case (op_r)
        OP_INSERT: begin
          if (ins_en) begin
            count_nxt = CNT_W'(count_r + 1'b1);
          end else if (!eq_any) begin
            ovf_nxt = 1'b1;
          end
        end
        OP_CLEAR: begin
          count_nxt = '0;
          ovf_nxt   = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_comb begin
    // no boundary means every stored color is smaller
    rank_full  = sel_any ? CNT_W'(sel_idx) : count_r;
    rank_wide  = WIDE'(rank_full);
    count_wide = WIDE'(count_nxt);
    res_rank   = '0;
    res_found  = 1'b0;
    res_color  = '0;
    unique case (op_r)
      OP_INSERT, OP_LOOKUP: begin
        res_rank  = (rank_wide > WIDE'(RANK_MAX)) ? RANK_W'(RANK_MAX)
                                                  : rank_wide[RANK_W-1:0];
        res_found = eq_any || ins_en;
      end
      OP_READ: begin
        if (sel_any) begin
          res_rank  = rank_in_r;
          res_found = 1'b1;
          res_color = sel_color;
        end
      end
      OP_CLEAR: begin
      end
      default: begin
      end
    endcase
    res_count = (count_wide > WIDE'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                : count_wide[COUNT_W-1:0];
    if (count_wide <= WIDE'(BYTE_INDEX_LIMIT)) begin
      res_ib = IB_ONE;
    end else if (count_wide <= WIDE'(SHORT_INDEX_LIMIT)) begin
      res_ib = IB_TWO;
    end else begin
      res_ib = IB_FOUR;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      pend_rank_r  <= res_rank;
      pend_found_r <= res_found;
      pend_color_r <= res_color;
      pend_count_r <= res_count;
      pend_ib_r    <= res_ib;
      pend_ovf_r   <= ovf_nxt;
    end
  end

  // ---------------------------------------------------------------- output
  logic               out_valid_r;
  logic [RANK_W-1:0]  out_rank_r;
  logic               out_found_r;
  logic [COLOR_W-1:0] out_color_r;
  logic [COUNT_W-1:0] out_count_r;
  logic [IB_W-1:0]    out_ib_r;
  logic               out_ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_rank_r  <= pend_rank_r;
      out_found_r <= pend_found_r;
      out_color_r <= pend_color_r;
      out_count_r <= pend_count_r;
      out_ib_r    <= pend_ib_r;
      out_ovf_r   <= pend_ovf_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_color_rank    = out_rank_r;
  assign out_found         = out_found_r;
  assign out_palette_color = out_color_r;
  assign out_unique_count  = out_count_r;
  assign out_index_bytes   = out_ib_r;
  assign out_overflow      = out_ovf_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_COLORS))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (count_r != $past(count_r))) |->
      ((count_r == '0) || (count_r == CNT_W'($past(count_r) + 1'b1))))
    else $error("entry count moved by more than one insert");

  a_out_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result shown without a finished item");
`endif

endmodule

`default_nettype wire

/* rtl/spi_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module spi_cell #(
  parameter int IDX = 0,
  parameter int IW  = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  spi_pkg::cmd_t                  cmd,
  input  spi_pkg::link_t                 prev,
  output spi_pkg::link_t                 link,
  output logic [2+IW+spi_pkg::COLOR_W-1:0] con
);
  import spi_pkg::*;

  localparam int CW = 2 + IW + COLOR_W;

  logic [COLOR_W-1:0] color_r;
  logic               valid_r;
  logic               lt_r;
  logic [CW-1:0]      con_r;

  logic               lt_now;
  logic               eq_now;
  logic               sel_now;
  logic [CW-1:0]      con_nxt;

  always_comb begin
    lt_now = valid_r && (color_r < cmd.color);
    eq_now = valid_r && (color_r == cmd.color);
    if (cmd.op == OP_READ) begin
      sel_now = valid_r && (int'(cmd.rank_in) == IDX);
    end else begin
      // first entry that is not smaller: the rank boundary
      sel_now = !lt_now && prev.lt_now;
    end
    con_nxt = sel_now ? {1'b1, eq_now, IW'(IDX), color_r} : {1'b0, eq_now, {(CW-2){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.clr) begin
      valid_r <= 1'b0;
    end else if (cmd.ins && !lt_r) begin
      valid_r <= prev.lt_r ? 1'b1 : prev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      lt_r  <= lt_now;
      con_r <= con_nxt;
    end
    // entries at and above the boundary move up by one
    if (cmd.ins && !lt_r) begin
      color_r <= prev.lt_r ? cmd.color : prev.color;
    end
  end

  assign link = '{color: color_r, valid: valid_r, lt_now: lt_now, lt_r: lt_r};
  assign con  = con_r;

endmodule

`default_nettype wire

/* rtl/spi_or_stage.sv */
`timescale 1ns / 1ps
`default_nettype none

module spi_or_stage #(
  parameter int NI = 32,
  parameter int NO = 1,
  parameter int W  = 36
) (
  input  logic                  clk,
  input  wire  [NI-1:0][W-1:0]  din,
  output wire  [NO-1:0][W-1:0]  dout
);
  import spi_pkg::*;

  logic [NO-1:0][W-1:0] grp_nxt;
  logic [NO-1:0][W-1:0] grp_r;

  // at most one contributor per group carries a select, so OR merges them
  always_comb begin
    grp_nxt = '0;
    for (int j = 0; j < NO; j++) begin
      for (int k = 0; k < FANIN; k++) begin
        if (j * FANIN + k < NI) begin
          grp_nxt[j] = grp_nxt[j] | din[j * FANIN + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
  end

  assign dout = grp_r;

endmodule

`default_nettype wire
